[rtl/errs_pkg.sv]
// Shared constants, command codes and control/status types of the error report scheduler.
`timescale 1ns / 1ps
`default_nettype none
package errs_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FLAT_W      = IDX_W + 1;
   localparam int MEM_DEPTH   = 2 ** FLAT_W;
   localparam int CODE_W      = 8;
   localparam int DATA_W      = 32;
   localparam int CMD_W       = 2;

   localparam logic [CMD_W-1:0]  CMD_REGISTER = 2'd0;
   localparam logic [CMD_W-1:0]  CMD_TICK     = 2'd1;
   localparam logic [CMD_W-1:0]  CMD_CLEAR    = 2'd2;

   localparam logic [CODE_W-1:0] EMPTY_CODE   = 8'hFF;

   typedef struct packed {
      logic load_req;
      logic tick_inc;
      logic scan_start;
      logic scan_run;
      logic do_reg;
      logic do_rearm;
      logic do_clear;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             reserved;
      logic             level;
      logic             rearm_pending;
      logic             scan_done;
      logic             out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

[rtl/errs_dp.sv]
// Datapath: error tables, entry memories, tick counter, scan pipeline and result registers.
`timescale 1ns / 1ps
`default_nettype none
module errs_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire errs_pkg::ctrl_cmd_type     cmd,
   output errs_pkg::dp_stat_type           stat,
   input  wire logic [1:0]                 req_command,
   input  wire logic [7:0]                 req_error_code,
   input  wire logic                       req_level,
   input  wire logic [31:0]                req_utc_time,
   input  wire logic [31:0]                req_repeat_interval,
   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_write_data,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_status,
   output logic                            rsp_report_valid,
   output logic [7:0]                      rsp_report_code,
   output logic                            rsp_report_level,
   output logic [31:0]                     rsp_report_utc,
   output logic [31:0]                     rsp_report_interval,
   output logic [31:0]                     rsp_report_stamp
);
   import errs_pkg::*;

   logic [CMD_W-1:0]  op_ff;
   logic [CODE_W-1:0] code_ff;
   logic              lvl_ff;
   logic [DATA_W-1:0] utc_ff;
   logic [DATA_W-1:0] ivl_ff;
   logic              report_enable_ff;
   logic [DATA_W-1:0] tick_ff;
   logic [IDX_W-1:0]  ring_ff;

   logic [CODE_W-1:0] o_codes_ff [TABLE_DEPTH];
   logic [CODE_W-1:0] p_codes_ff [TABLE_DEPTH];

   logic [DATA_W-1:0] time_mem  [MEM_DEPTH];
   logic [DATA_W-1:0] ivl_mem   [MEM_DEPTH];
   logic [DATA_W-1:0] stamp_mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_time_ff;
   logic [DATA_W-1:0] rd_ivl_ff;
   logic [DATA_W-1:0] rd_stamp_ff;

   logic              scan_lvl_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              eval_vld_ff;
   logic              eval_lvl_ff;
   logic [IDX_W-1:0]  eval_idx_ff;

   logic              st_status_ff;
   logic              st_rv_ff;
   logic [CODE_W-1:0] st_code_ff;
   logic              st_level_ff;
   logic [DATA_W-1:0] st_utc_ff;
   logic [DATA_W-1:0] st_ivl_ff;
   logic [DATA_W-1:0] st_stamp_ff;

   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic              rsp_rv_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_level_ff;
   logic [DATA_W-1:0] rsp_utc_ff;
   logic [DATA_W-1:0] rsp_ivl_ff;
   logic [DATA_W-1:0] rsp_stamp_ff;

   logic              m0_any;
   logic [IDX_W-1:0]  m0_idx;
   logic              m1_any;
   logic              e1_any;
   logic [IDX_W-1:0]  e1_idx;
   logic [CODE_W-1:0] eval_code;
   logic [DATA_W-1:0] age;
   logic              eval_hit;
   logic              eval_last;
   logic              scan_done;
   logic              rearm_due;
   logic [FLAT_W-1:0] rd_addr;
   logic [FLAT_W-1:0] wr_addr;
   logic              wr_time_en;
   logic              wr_ivl_en;
   logic              wr_stamp_en;
   logic [DATA_W-1:0] wr_stamp_data;
   logic              new0;
   logic              new1;

   always_comb begin
      m0_any = 1'b0;
      m0_idx = '0;
      m1_any = 1'b0;
      e1_any = 1'b0;
      e1_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!m0_any && o_codes_ff[i] == code_ff) begin
            m0_any = 1'b1;
            m0_idx = IDX_W'(i);
         end
         if (p_codes_ff[i] == code_ff) begin
            m1_any = 1'b1;
         end
         if (!e1_any && p_codes_ff[i] == EMPTY_CODE) begin
            e1_any = 1'b1;
            e1_idx = IDX_W'(i);
         end
      end
   end

   assign eval_code = eval_lvl_ff ? p_codes_ff[eval_idx_ff] : o_codes_ff[eval_idx_ff];
   assign age       = tick_ff - rd_stamp_ff;
   assign rearm_due = age > rd_ivl_ff;
   assign eval_hit  = eval_vld_ff && (eval_code != EMPTY_CODE) &&
                      ((rd_stamp_ff == '0) || (eval_lvl_ff && rearm_due));
   assign eval_last = eval_lvl_ff && (eval_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign scan_done = eval_vld_ff && (eval_hit || eval_last);
   assign rd_addr   = (op_ff == CMD_TICK) ? {scan_lvl_ff, scan_idx_ff} : {1'b0, m0_idx};
   assign new0      = cmd.do_reg && !lvl_ff && !m0_any;
   assign new1      = cmd.do_reg && lvl_ff && !m1_any && e1_any;

   always_comb begin
      wr_addr       = {1'b0, ring_ff};
      wr_time_en    = 1'b0;
      wr_ivl_en     = 1'b0;
      wr_stamp_en   = 1'b0;
      wr_stamp_data = '0;
      if (new0) begin
         wr_addr     = {1'b0, ring_ff};
         wr_time_en  = 1'b1;
         wr_ivl_en   = 1'b1;
         wr_stamp_en = 1'b1;
      end else if (new1) begin
         wr_addr     = {1'b1, e1_idx};
         wr_time_en  = 1'b1;
         wr_ivl_en   = 1'b1;
         wr_stamp_en = 1'b1;
      end else if (cmd.do_rearm && rearm_due) begin
         wr_addr     = {1'b0, m0_idx};
         wr_time_en  = 1'b1;
         wr_stamp_en = 1'b1;
      end else if (cmd.scan_run && eval_hit) begin
         wr_addr       = {eval_lvl_ff, eval_idx_ff};
         wr_stamp_en   = 1'b1;
         wr_stamp_data = tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_time_en) begin
         time_mem[wr_addr] <= utc_ff;
      end
      if (wr_ivl_en) begin
         ivl_mem[wr_addr] <= ivl_ff;
      end
      if (wr_stamp_en) begin
         stamp_mem[wr_addr] <= wr_stamp_data;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_ivl_ff   <= ivl_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            o_codes_ff[i] <= EMPTY_CODE;
            p_codes_ff[i] <= EMPTY_CODE;
         end
         ring_ff          <= '0;
         tick_ff          <= '0;
         report_enable_ff <= 1'b0;
         eval_vld_ff      <= 1'b0;
         scan_lvl_ff      <= 1'b0;
         scan_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            report_enable_ff <= csr_write_data;
         end
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + 32'd1;
         end
         if (new0) begin
            o_codes_ff[ring_ff] <= code_ff;
            ring_ff <= (ring_ff == IDX_W'(TABLE_DEPTH - 1)) ? '0 : ring_ff + 1'b1;
         end
         if (new1) begin
            p_codes_ff[e1_idx] <= code_ff;
         end
         if (cmd.do_clear) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!lvl_ff && o_codes_ff[i] == code_ff) begin
                  o_codes_ff[i] <= EMPTY_CODE;
               end
               if (lvl_ff && p_codes_ff[i] == code_ff) begin
                  p_codes_ff[i] <= EMPTY_CODE;
               end
            end
         end
         if (cmd.scan_start) begin
            scan_lvl_ff <= 1'b0;
            scan_idx_ff <= '0;
            eval_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            eval_vld_ff <= 1'b1;
            if (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               scan_idx_ff <= '0;
               scan_lvl_ff <= 1'b1;
            end else begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff        <= req_command;
         code_ff      <= req_error_code;
         lvl_ff       <= req_level;
         utc_ff       <= req_utc_time;
         ivl_ff       <= req_repeat_interval;
         st_status_ff <= 1'b0;
         st_rv_ff     <= 1'b0;
         st_code_ff   <= '0;
         st_level_ff  <= 1'b0;
         st_utc_ff    <= '0;
         st_ivl_ff    <= '0;
         st_stamp_ff  <= '0;
      end else if (cmd.scan_run && scan_done) begin
         if (!eval_hit) begin
            st_status_ff <= 1'b1;
         end else if (report_enable_ff) begin
            st_rv_ff    <= 1'b1;
            st_code_ff  <= eval_code;
            st_level_ff <= eval_lvl_ff;
            st_utc_ff   <= rd_time_ff;
            st_ivl_ff   <= rd_ivl_ff;
            st_stamp_ff <= tick_ff;
         end
      end
      if (cmd.scan_run) begin
         eval_lvl_ff <= scan_lvl_ff;
         eval_idx_ff <= scan_idx_ff;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= st_status_ff;
         rsp_rv_ff     <= st_rv_ff;
         rsp_code_ff   <= st_code_ff;
         rsp_level_ff  <= st_level_ff;
         rsp_utc_ff    <= st_utc_ff;
         rsp_ivl_ff    <= st_ivl_ff;
         rsp_stamp_ff  <= st_stamp_ff;
      end
   end

   always_comb begin
      stat.op            = op_ff;
      stat.reserved      = (code_ff == EMPTY_CODE);
      stat.level         = lvl_ff;
      stat.rearm_pending = m0_any;
      stat.scan_done     = scan_done;
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_report_valid    = rsp_rv_ff;
   assign rsp_report_code     = rsp_code_ff;
   assign rsp_report_level    = rsp_level_ff;
   assign rsp_report_utc      = rsp_utc_ff;
   assign rsp_report_interval = rsp_ivl_ff;
   assign rsp_report_stamp    = rsp_stamp_ff;

endmodule
`default_nettype wire

[rtl/errs_ctrl.sv]
// Controller state machine that sequences one request beat through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module errs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire errs_pkg::dp_stat_type  stat,
   output errs_pkg::ctrl_cmd_type      cmd
);
   import errs_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_REG      = 3'd3;
   localparam logic [2:0] S_REARM    = 3'd4;
   localparam logic [2:0] S_CLEAR    = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               CMD_TICK: begin
                  cmd.tick_inc   = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
               CMD_REGISTER: begin
                  state_in = stat.reserved ? S_FINISH : S_REG;
               end
               CMD_CLEAR: begin
                  state_in = stat.reserved ? S_FINISH : S_CLEAR;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_REG: begin
            cmd.do_reg = 1'b1;
            state_in   = (!stat.level && stat.rearm_pending) ? S_REARM : S_FINISH;
         end
         S_REARM: begin
            cmd.do_rearm = 1'b1;
            state_in     = S_FINISH;
         end
         S_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/error_record_report_scheduler_unit.sv]
// Top level of the error record and report scheduler.
`timescale 1ns / 1ps
`default_nettype none
// The req channel takes one command beat: register an error, tick, or clear an error.
// Every request beat yields exactly one rsp beat carrying the status and, for a tick
// that finds an entry due while reporting is enabled, the reported entry's fields.
// The csr port writes the report-enable bit; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// A tick scans both tables one entry per cycle through the registered read port of the
// entry memories, stopping at the first entry that is due.
// One request is in work at a time; the next beat is accepted as soon as the previous
// result sits in the output register, even while the receiver has not taken it.
// When the receiver stalls, the output register holds its beat and a finished result
// waits in the staging registers, with the controller holding, until the register frees up.
// Reset empties both tables, zeroes the tick counter and the ring pointer, clears the
// report-enable bit and drops any pending response; no clearing pass is needed.
module error_record_report_scheduler_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_error_code,
   input  wire logic        req_level,
   input  wire logic [31:0] req_utc_time,
   input  wire logic [31:0] req_repeat_interval,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic             rsp_report_valid,
   output logic [7:0]       rsp_report_code,
   output logic             rsp_report_level,
   output logic [31:0]      rsp_report_utc,
   output logic [31:0]      rsp_report_interval,
   output logic [31:0]      rsp_report_stamp,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   import errs_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   errs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   errs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_error_code      (req_error_code),
      .req_level           (req_level),
      .req_utc_time        (req_utc_time),
      .req_repeat_interval (req_repeat_interval),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_report_code     (rsp_report_code),
      .rsp_report_level    (rsp_report_level),
      .rsp_report_utc      (rsp_report_utc),
      .rsp_report_interval (rsp_report_interval),
      .rsp_report_stamp    (rsp_report_stamp)
   );

   // A reported entry never comes with the nothing-due status.
   a_report_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_valid) |-> !rsp_status)
      else $error("report beat carries nothing-due status");

   // In the cycle after a request beat is taken the controller is busy.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in work");

   // A result is moved to the output register only when that register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("output beat overwritten before it was taken");

   // The re-arm check only runs for a one-shot register command.
   a_rearm_scope: assert property (@(posedge clock) disable iff (reset)
      cmd.do_rearm |-> (stat.op == CMD_REGISTER && !stat.level && stat.rearm_pending))
      else $error("re-arm check outside a one-shot register command");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the error record and report scheduler, with a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
   import errs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;
   localparam logic             LEVEL_ONESHOT    = 1'b0;
   localparam logic             LEVEL_PERSISTENT = 1'b1;
   localparam logic [31:0]      WORD_MAX         = 32'hFFFF_FFFF;
   localparam int               DIRECTED_ROWS    = 23;
   localparam int               PHASES           = 4;
   localparam int               PHASE_ITEMS      = 250;
   localparam int               SETTLE_CYCLES    = 4 * TABLE_DEPTH + 8;
   localparam int               STALL_CYCLES     = 400;
   localparam int               STALL_AFTER      = 300;

   typedef struct packed {
      logic        status;
      logic        valid;
      logic [7:0]  code;
      logic        level;
      logic [31:0] utc;
      logic [31:0] interval;
      logic [31:0] stamp;
   } sched_outcome_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        code;
      logic              level;
      logic [31:0]       utc;
      logic [31:0]       interval;
      bit                typed;
      sched_outcome_type outcome;
   } stim_row_type;

   localparam sched_outcome_type OUTCOME_DONE = '0;
   localparam sched_outcome_type OUTCOME_IDLE =
      '{1'b1, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 32'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_REGISTER;
   logic [7:0]  req_error_code = 8'd0;
   logic        req_level = 1'b0;
   logic [31:0] req_utc_time = 32'd0;
   logic [31:0] req_repeat_interval = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic        rsp_report_valid;
   logic [7:0]  rsp_report_code;
   logic        rsp_report_level;
   logic [31:0] rsp_report_utc;
   logic [31:0] rsp_report_interval;
   logic [31:0] rsp_report_stamp;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   logic [7:0]       shot_code [TABLE_DEPTH];
   logic [31:0]      shot_utc [TABLE_DEPTH];
   logic [31:0]      shot_ivl [TABLE_DEPTH];
   logic [31:0]      shot_stamp [TABLE_DEPTH];
   logic [7:0]       keep_code [TABLE_DEPTH];
   logic [31:0]      keep_utc [TABLE_DEPTH];
   logic [31:0]      keep_ivl [TABLE_DEPTH];
   logic [31:0]      keep_stamp [TABLE_DEPTH];
   logic [IDX_W-1:0] ring_slot;
   logic [31:0]      tick_now;
   logic             reporting_on;

   sched_outcome_type expected_outcomes [$];
   sched_outcome_type want;
   sched_outcome_type got;
   int                failures = 0;
   int                beats_checked = 0;
   bit                no_idle = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b1, OUTCOME_IDLE},
      '{CMD_REGISTER, EMPTY_CODE, LEVEL_ONESHOT, WORD_MAX, WORD_MAX, 1'b1, OUTCOME_DONE},
      '{CMD_CLEAR, EMPTY_CODE, LEVEL_PERSISTENT, 32'd0, 32'd0, 1'b1, OUTCOME_DONE},
      '{CMD_UNUSED, 8'd254, LEVEL_PERSISTENT, WORD_MAX, WORD_MAX, 1'b1, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b1, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b1,
        '{1'b0, 1'b1, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 32'd2}},
      '{CMD_REGISTER, 8'd254, LEVEL_PERSISTENT, WORD_MAX, WORD_MAX, 1'b1, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b1,
        '{1'b0, 1'b1, 8'd254, LEVEL_PERSISTENT, WORD_MAX, WORD_MAX, 32'd3}},
      '{CMD_TICK, 8'd128, LEVEL_PERSISTENT, WORD_MAX, WORD_MAX, 1'b0, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd0, LEVEL_ONESHOT, 32'h1234_5678, 32'd5, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd0, LEVEL_ONESHOT, 32'hAAAA_AAAA, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd7, LEVEL_PERSISTENT, 32'h5555_5555, 32'd1, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd254, LEVEL_PERSISTENT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_CLEAR, 8'd254, LEVEL_PERSISTENT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_CLEAR, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_CLEAR, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_REGISTER, 8'd128, LEVEL_ONESHOT, 32'h8000_0000, 32'h8000_0000, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE},
      '{CMD_TICK, 8'd0, LEVEL_ONESHOT, 32'd0, 32'd0, 1'b0, OUTCOME_DONE}
   };

   error_record_report_scheduler_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_error_code      (req_error_code),
      .req_level           (req_level),
      .req_utc_time        (req_utc_time),
      .req_repeat_interval (req_repeat_interval),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_report_code     (rsp_report_code),
      .rsp_report_level    (rsp_report_level),
      .rsp_report_utc      (rsp_report_utc),
      .rsp_report_interval (rsp_report_interval),
      .rsp_report_stamp    (rsp_report_stamp),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int draw_gap_cycles();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 65)
         return 0;
      else if (r < 90)
         return $urandom_range(3, 1);
      else
         return $urandom_range(30, 6);
   endfunction

   function automatic sched_outcome_type stamp_report(input logic [7:0] code,
         input logic lvl, input logic [31:0] utc, input logic [31:0] ivl);
      sched_outcome_type res;
      res = OUTCOME_DONE;
      if (reporting_on) begin
         res.valid = 1'b1;
         res.code = code;
         res.level = lvl;
         res.utc = utc;
         res.interval = ivl;
         res.stamp = tick_now;
      end
      return res;
   endfunction

   function automatic sched_outcome_type predict_outcome(input logic [1:0] cmd,
         input logic [7:0] code, input logic lvl, input logic [31:0] utc,
         input logic [31:0] ivl);
      sched_outcome_type res;
      logic [31:0]       age;
      bit                found;
      int                i;
      res = OUTCOME_DONE;
      found = 1'b0;
      if (cmd == CMD_REGISTER && code != EMPTY_CODE) begin
         if (lvl == LEVEL_ONESHOT) begin
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (!found && shot_code[i] == code) begin
                  found = 1'b1;
                  age = tick_now - shot_stamp[i];
                  if (age > shot_ivl[i]) begin
                     shot_stamp[i] = 32'd0;
                     shot_utc[i] = utc;
                  end
               end
            end
            if (!found) begin
               shot_code[ring_slot] = code;
               shot_utc[ring_slot] = utc;
               shot_ivl[ring_slot] = ivl;
               shot_stamp[ring_slot] = 32'd0;
               ring_slot = (ring_slot == IDX_W'(TABLE_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
            end
         end else begin
            for (i = 0; i < TABLE_DEPTH; i++)
               if (keep_code[i] == code)
                  found = 1'b1;
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (!found && keep_code[i] == EMPTY_CODE) begin
                  found = 1'b1;
                  keep_code[i] = code;
                  keep_utc[i] = utc;
                  keep_ivl[i] = ivl;
                  keep_stamp[i] = 32'd0;
               end
            end
         end
      end else if (cmd == CMD_TICK) begin
         tick_now = tick_now + 32'd1;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            if (!found && shot_code[i] != EMPTY_CODE && shot_stamp[i] == 32'd0) begin
               found = 1'b1;
               shot_stamp[i] = tick_now;
               res = stamp_report(shot_code[i], LEVEL_ONESHOT, shot_utc[i], shot_ivl[i]);
            end
         end
         for (i = 0; i < TABLE_DEPTH; i++) begin
            age = tick_now - keep_stamp[i];
            if (!found && keep_code[i] != EMPTY_CODE &&
                  (keep_stamp[i] == 32'd0 || age > keep_ivl[i])) begin
               found = 1'b1;
               keep_stamp[i] = tick_now;
               res = stamp_report(keep_code[i], LEVEL_PERSISTENT, keep_utc[i], keep_ivl[i]);
            end
         end
         if (!found)
            res.status = 1'b1;
      end else if (cmd == CMD_CLEAR && code != EMPTY_CODE) begin
         for (i = 0; i < TABLE_DEPTH; i++) begin
            if (lvl == LEVEL_ONESHOT && shot_code[i] == code)
               shot_code[i] = EMPTY_CODE;
            if (lvl == LEVEL_PERSISTENT && keep_code[i] == code)
               keep_code[i] = EMPTY_CODE;
         end
      end
      return res;
   endfunction

   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] code, input logic lvl,
         input logic [31:0] utc, input logic [31:0] ivl, input bit typed,
         input sched_outcome_type fixed);
      sched_outcome_type predicted;
      int                gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_error_code <= code;
      req_level <= lvl;
      req_utc_time <= utc;
      req_repeat_interval <= ivl;
      do @(posedge clock); while (!req_ready);
      predicted = predict_outcome(cmd, code, lvl, utc, ivl);
      expected_outcomes.push_back(typed ? fixed : predicted);
      gap = draw_gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_report_enable(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      reporting_on = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_value,
         input logic [31:0] act_value);
      if (act_value !== exp_value) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_value,
            act_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_report_valid, rsp_report_code, rsp_report_level,
                 rsp_report_utc, rsp_report_interval, rsp_report_stamp};
         if (expected_outcomes.size() == 0) begin
            $display("%0t: response beat with no expected value, actual %h", $time, got);
            failures++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status", want.status, got.status);
            check_field("report_valid", want.valid, got.valid);
            check_field("report_code", want.code, got.code);
            check_field("report_level", want.level, got.level);
            check_field("report_utc", want.utc, got.utc);
            check_field("report_interval", want.interval, got.interval);
            check_field("report_stamp", want.stamp, got.stamp);
         end
         beats_checked++;
      end
   end

   // The single long hold-off lets the output side back up into the request channel.
   initial begin : response_side
      int hold;
      bit long_stall_done;
      long_stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_stall_done && beats_checked >= STALL_AFTER) begin
            long_stall_done = 1'b1;
            hold = STALL_CYCLES;
         end else begin
            hold = draw_gap_cycles();
         end
         if (hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : request_side
      int          k;
      int          n;
      int          phase;
      int          r;
      logic [1:0]  cmd;
      logic [7:0]  code;
      logic        lvl;
      logic [31:0] utc;
      logic [31:0] ivl;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         shot_code[k] = EMPTY_CODE;
         keep_code[k] = EMPTY_CODE;
         shot_utc[k] = 32'd0;
         shot_ivl[k] = 32'd0;
         shot_stamp[k] = 32'd0;
         keep_utc[k] = 32'd0;
         keep_ivl[k] = 32'd0;
         keep_stamp[k] = 32'd0;
      end
      ring_slot = '0;
      tick_now = 32'd0;
      reporting_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_report_enable(1'b1);
      for (n = 0; n < DIRECTED_ROWS; n++)
         send_beat(directed_rows[n].command, directed_rows[n].code, directed_rows[n].level,
            directed_rows[n].utc, directed_rows[n].interval, directed_rows[n].typed,
            directed_rows[n].outcome);
      req_valid <= 1'b0;
      wait_until_drained();
      for (phase = 0; phase < PHASES; phase++) begin
         no_idle = (phase == 2);
         write_report_enable(phase[0]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 42)
               cmd = CMD_REGISTER;
            else if (r < 82)
               cmd = CMD_TICK;
            else if (r < 96)
               cmd = CMD_CLEAR;
            else
               cmd = CMD_UNUSED;
            r = $urandom_range(99);
            if (r < 85)
               code = 8'($urandom_range(11));
            else if (r < 97)
               code = 8'($urandom_range(254));
            else
               code = EMPTY_CODE;
            lvl = 1'($urandom_range(1));
            utc = $urandom;
            r = $urandom_range(99);
            if (r < 50)
               ivl = $urandom_range(6);
            else if (r < 80)
               ivl = $urandom_range(40);
            else if (r < 95)
               ivl = $urandom;
            else
               ivl = WORD_MAX;
            send_beat(cmd, code, lvl, utc, ivl, 1'b0, OUTCOME_DONE);
         end
         req_valid <= 1'b0;
         wait_until_drained();
      end
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
